// ===== sv/hpd_pkg.sv =====
// Shared types and constants for the heartbeat peak detector.
// Used by the register block, controller, datapath and top level.
package hpd_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int TIME_W   = 32;
  localparam int CNT_W    = 8;
  localparam int SUM_W    = 36;
  localparam int BEATS_W  = 4;
  localparam int BPM_W    = 20;

  // Stream word layout
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 56;
  localparam int M_TUSER_W = 3;

  // Beat statistics
  localparam logic [BEATS_W-1:0] BEATS_PER_BPM = 4'd10;
  localparam logic [BPM_W-1:0]   BPM_NUMERATOR = 20'd600000;
  localparam logic [CNT_W-1:0]   COUNTER_MAX   = 8'd255;

  // Divider: one quotient bit per step
  localparam int DIV_STEPS = BPM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Register file
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_NF_LOW  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NF_HIGH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CONFIRM = 2'd2;

  localparam logic [SAMPLE_W-1:0] NF_LOW_RST  = 12'd2000;
  localparam logic [SAMPLE_W-1:0] NF_HIGH_RST = 12'd2090;
  localparam logic [CNT_W-1:0]    CONFIRM_RST = 8'd15;

  typedef struct packed {
    logic [SAMPLE_W-1:0] nf_low;
    logic [SAMPLE_W-1:0] nf_high;
    logic [CNT_W-1:0]    confirm_count;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_needed;
    logic div_last;
  } dp_status_t;

endpackage

// ===== sv/hpd_cfg_regs.sv =====
// APB configuration registers of the heartbeat peak detector.
// Depends on hpd_pkg for register indexes, reset values and cfg_t.
module hpd_cfg_regs import hpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  // Write registers; unmapped indexes drop the word
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nf_low        <= NF_LOW_RST;
      cfg.nf_high       <= NF_HIGH_RST;
      cfg.confirm_count <= CONFIRM_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NF_LOW:  cfg.nf_low        <= pwdata[SAMPLE_W-1:0];
        REG_NF_HIGH: cfg.nf_high       <= pwdata[SAMPLE_W-1:0];
        REG_CONFIRM: cfg.confirm_count <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_NF_LOW:  prdata = APB_DATA_W'(cfg.nf_low);
      REG_NF_HIGH: prdata = APB_DATA_W'(cfg.nf_high);
      REG_CONFIRM: prdata = APB_DATA_W'(cfg.confirm_count);
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== sv/hpd_ctrl.sv =====
// Sequencing state machine of the heartbeat peak detector.
// Depends on hpd_pkg for the datapath command and status structs.
module hpd_ctrl import hpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;

  assign s_tready  = (state == ST_IDLE);
  assign slot_free = !m_tvalid || m_tready;

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd.load_in  = 1'b0;
    cmd.eval     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.emit     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.load_in = s_tvalid;
        if (s_tvalid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = status.div_needed ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = slot_free;
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the output word until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// ===== sv/hpd_dp.sv =====
// Datapath of the heartbeat peak detector: peak/trough tracking, beat
// statistics, bit-serial BPM divider and output register. Depends on hpd_pkg.
module hpd_dp import hpd_pkg::*; #(
  parameter int ADC_MAX = 4095
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  cfg_t                 cfg,
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic [M_TUSER_W-1:0] m_tuser
);

  localparam int ADC_W = $clog2(ADC_MAX + 1);
  localparam int EXT_W = (ADC_W > SAMPLE_W) ? ADC_W : SAMPLE_W;
  localparam int PAD_W = M_TDATA_W - TIME_W - BPM_W;

  // Latched input word
  logic [SAMPLE_W-1:0] in_sample;
  logic [TIME_W-1:0]   in_time;

  // Tracking and beat state
  logic                rising;
  logic [EXT_W-1:0]    extreme;
  logic [CNT_W-1:0]    confirm_counter;
  logic [TIME_W-1:0]   last_beat_time;
  logic [SUM_W-1:0]    interval_sum;
  logic [BEATS_W-1:0]  beats_in_sum;
  logic [BPM_W-1:0]    bpm_hold;

  logic                rising_next;
  logic [EXT_W-1:0]    extreme_next;
  logic [CNT_W-1:0]    counter_next;
  logic [TIME_W-1:0]   last_next;
  logic [SUM_W-1:0]    sum_next;
  logic [BEATS_W-1:0]  beats_next;
  logic [BPM_W-1:0]    bpm_next;

  // Pending result fields
  logic                res_finger;
  logic                res_beat;
  logic                res_valid;
  logic [TIME_W-1:0]   res_interval;

  // Evaluation terms
  logic                in_band;
  logic [EXT_W-1:0]    sample_x;
  logic [CNT_W-1:0]    cnt_bumped;
  logic                turn;
  logic [TIME_W-1:0]   interval;
  logic [SUM_W-1:0]    sum_new;
  logic [BEATS_W-1:0]  beats_new;
  logic                beat_c;
  logic                valid_c;
  logic                div_needed_c;

  // Divider
  logic [SUM_W-1:0]    div_den;
  logic [SUM_W-1:0]    div_rem;
  logic [BPM_W-1:0]    div_quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SUM_W:0]      trial;
  logic [SUM_W:0]      trial_diff;
  logic                trial_ge;
  logic [SUM_W-1:0]    rem_next;
  logic [BPM_W-1:0]    quo_next;

  assign in_band    = (in_sample >= cfg.nf_low) && (in_sample <= cfg.nf_high);
  assign sample_x   = EXT_W'(in_sample);
  assign cnt_bumped = (confirm_counter == COUNTER_MAX) ? confirm_counter
                                                       : confirm_counter + 1'b1;
  assign turn       = cnt_bumped > cfg.confirm_count;
  assign interval   = in_time - last_beat_time;
  assign sum_new    = interval_sum + SUM_W'(interval);
  assign beats_new  = beats_in_sum + 1'b1;

  // Next tracking state for the latched sample
  always_comb begin
    rising_next  = rising;
    extreme_next = extreme;
    counter_next = confirm_counter;
    last_next    = last_beat_time;
    sum_next     = interval_sum;
    beats_next   = beats_in_sum;
    bpm_next     = bpm_hold;
    beat_c       = 1'b0;
    valid_c      = 1'b0;
    div_needed_c = 1'b0;
    if (!in_band) begin
      if (rising) begin
        if (sample_x <= extreme) begin
          counter_next = cnt_bumped;
          // Rise-to-fall turn: a beat
          if (turn) begin
            rising_next  = 1'b0;
            extreme_next = EXT_W'(ADC_MAX);
            last_next    = in_time;
            beat_c       = 1'b1;
            sum_next     = sum_new;
            beats_next   = beats_new;
            if (beats_new == BEATS_PER_BPM) begin
              sum_next   = '0;
              beats_next = '0;
              valid_c    = 1'b1;
              if (sum_new == '0) begin
                bpm_next = BPM_NUMERATOR;
              end else begin
                div_needed_c = 1'b1;
              end
            end
          end
        end else begin
          extreme_next = sample_x;
          counter_next = '0;
        end
      end else begin
        if (sample_x >= extreme) begin
          counter_next = cnt_bumped;
          if (turn) begin
            rising_next  = 1'b1;
            extreme_next = '0;
          end
        end else begin
          extreme_next = sample_x;
          counter_next = '0;
        end
      end
    end
  end

  // Restoring division step: one quotient bit
  assign trial      = {div_rem, div_quo[BPM_W-1]};
  assign trial_diff = trial - {1'b0, div_den};
  assign trial_ge   = trial >= {1'b0, div_den};
  assign rem_next   = trial_ge ? trial_diff[SUM_W-1:0] : trial[SUM_W-1:0];
  assign quo_next   = {div_quo[BPM_W-2:0], trial_ge};

  assign status.div_needed = div_needed_c;
  assign status.div_last   = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_sample <= s_tdata[SAMPLE_W-1:0];
      in_time   <= s_tdata[SAMPLE_W +: TIME_W];
    end
  end

  // Commit tracking state; update bpm at the last divider step
  always_ff @(posedge clk) begin
    if (rst) begin
      rising          <= 1'b0;
      extreme         <= '0;
      confirm_counter <= '0;
      last_beat_time  <= '0;
      interval_sum    <= '0;
      beats_in_sum    <= '0;
      bpm_hold        <= '0;
    end else if (cmd.eval) begin
      rising          <= rising_next;
      extreme         <= extreme_next;
      confirm_counter <= counter_next;
      last_beat_time  <= last_next;
      interval_sum    <= sum_next;
      beats_in_sum    <= beats_next;
      bpm_hold        <= bpm_next;
    end else if (cmd.div_step && status.div_last) begin
      bpm_hold        <= quo_next;
    end
  end

  // Result fields of the current word
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_finger   <= !in_band;
      res_beat     <= beat_c;
      res_valid    <= valid_c;
      res_interval <= beat_c ? interval : '0;
    end
  end

  // Divider registers
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.eval) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      div_den <= sum_new;
      div_rem <= '0;
      div_quo <= BPM_NUMERATOR;
    end else if (cmd.div_step) begin
      div_rem <= rem_next;
      div_quo <= quo_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {{PAD_W{1'b0}}, bpm_hold, res_interval};
      m_tuser <= {res_valid, res_beat, res_finger};
    end
  end

endmodule

// ===== sv/heartbeat_peak_detector.sv =====
// Heartbeat peak detector: takes one pulse-sensor sample with its millisecond
// timestamp per word and returns one result word per sample. The block takes
// a sample in IDLE, evaluates it in EVAL and loads the output register in
// EMIT once the output slot is free; on every tenth beat with a nonzero
// interval sum a bit-serial divider (DIV, between EVAL and EMIT) computes
// 600000 / (sum of ten intervals) one quotient bit per cycle. A new sample can
// be accepted while the previous result still waits in the output register.
// Registers: no_finger_low at 0x0, no_finger_high at 0x4, confirm_count at 0x8.
module heartbeat_peak_detector import hpd_pkg::*; #(
  parameter int ADC_MAX = 4095
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Sample stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,  // sample[11:0], time_ms[43:12], zero pad
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,  // interval_ms[31:0], bpm[51:32], zero pad
  output logic [M_TUSER_W-1:0]  m_tuser   // finger_present[0], beat[1], bpm_valid[2]
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  hpd_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  hpd_dp #(
    .ADC_MAX (ADC_MAX)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .cfg     (cfg),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule
